>>> rtl/ppd_pkg.sv
// Package for the point-to-polyline distance block.
// Holds the field widths and stream packing constants; no dependencies.
`timescale 1ns / 1ps
package ppd_pkg;
  localparam int unsigned COORD_W    = 31;
  localparam int unsigned DIST_W     = 32;
  localparam int unsigned IN_TDATA_W = 128;
endpackage

>>> rtl/point_to_polyline_distance_top.sv
// Point-to-polyline distance: least distance from a query point to a streamed polyline.
// Depends on ppd_pkg. One shared 34x34 multiplier, a serial divider and a serial square root.
// A first vertex that is not last only stores its point; a segment runs the products, the clamp
// and, when the projection is inside the segment, the restoring division, then the squared
// distance; a degenerate segment goes straight to the squared distance. A last vertex adds the
// square root and the output transfer; the input is not ready again until that transfer completes.
// Reset (rst_ni low, asynchronous) clears the polyline state; the best square goes to all ones.
`timescale 1ns / 1ps
module point_to_polyline_distance_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // tdata: vertex_x [30:0], vertex_y [61:31], query_x [92:62], query_y [123:93], zero pad
  input  logic [ppd_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,
  input  logic                             s_axis_tlast_i, // last_vertex
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // tdata: distance [31:0]
  output logic [ppd_pkg::DIST_W-1:0]       m_axis_tdata_o
);
  import ppd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_NUM1, S_NUM2, S_DEN1, S_DEN2, S_CLAMP, S_DIV,
    S_OFFX, S_OFFY, S_RESY, S_SQX, S_SQY, S_SUM, S_SQRT, S_OUT
  } state_e;

  state_e state_q;

  // Polyline state.
  logic signed [COORD_W-1:0] prev_x_q, prev_y_q, hq_x_q, hq_y_q, cur_x_q, cur_y_q;
  logic                      have_prev_q, first_q, last_q;
  logic [63:0]               best_q;

  // Datapath registers.
  logic signed [31:0] px_q, py_q, dx_q, dy_q;
  logic signed [33:0] rx_q, ry_q;
  logic signed [65:0] num_q;
  logic [63:0]        den_q, rem_q, sq_q, bit_q, res_q;
  logic [32:0]        quo_q;
  logic [4:0]         cnt_q;
  logic signed [67:0] prod_q;
  logic [DIST_W-1:0]  dist_q;

  // Shared multiplier operand selection.
  logic signed [33:0] mul_a, mul_b;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_NUM1: begin mul_a = 34'(px_q); mul_b = 34'(dx_q); end
      S_NUM2: begin mul_a = 34'(py_q); mul_b = 34'(dy_q); end
      S_DEN1: begin mul_a = 34'(dx_q); mul_b = 34'(dx_q); end
      S_DEN2: begin mul_a = 34'(dy_q); mul_b = 34'(dy_q); end
      S_OFFX: begin mul_a = $signed({1'b0, quo_q}); mul_b = 34'(dx_q); end
      S_OFFY: begin mul_a = $signed({1'b0, quo_q}); mul_b = 34'(dy_q); end
      S_SQX:  begin mul_a = rx_q; mul_b = rx_q; end
      S_SQY:  begin mul_a = ry_q; mul_b = ry_q; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // Segment start and offsets. A first vertex acts as a degenerate segment onto itself.
  logic signed [COORD_W-1:0] sx, sy;
  logic signed [31:0]        px_d, py_d, dx_d, dy_d;
  assign sx   = first_q ? cur_x_q : prev_x_q;
  assign sy   = first_q ? cur_y_q : prev_y_q;
  assign px_d = 32'(hq_x_q) - 32'(sx);
  assign py_d = 32'(hq_y_q) - 32'(sy);
  assign dx_d = 32'(cur_x_q) - 32'(sx);
  assign dy_d = 32'(cur_y_q) - 32'(sy);

  logic [63:0] den_full;
  assign den_full = den_q + prod_q[63:0];

  logic [64:0] rem_sh;
  logic        div_ge;
  assign rem_sh = {rem_q, 1'b0};
  assign div_ge = rem_sh >= {1'b0, den_q};

  logic [64:0] sum65;
  logic [63:0] seg_sq, best_new;
  assign sum65    = {1'b0, sq_q} + {1'b0, prod_q[63:0]};
  assign seg_sq   = sum65[64] ? '1 : sum65[63:0];
  assign best_new = (seg_sq < best_q) ? seg_sq : best_q;

  // One step of the digit-by-digit square root.
  logic [63:0] trial, res_next;
  logic        sqrt_ge;
  assign trial    = res_q + bit_q;
  assign sqrt_ge  = rem_q >= trial;
  assign res_next = sqrt_ge ? ((res_q >> 1) + bit_q) : (res_q >> 1);

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = (state_q == S_OUT);
  assign m_axis_tdata_o  = dist_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      hq_x_q      <= '0;
      hq_y_q      <= '0;
      have_prev_q <= 1'b0;
      best_q      <= '1;
      first_q     <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      prod_q <= mul_a * mul_b;
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid_i) begin
            cur_x_q     <= s_axis_tdata_i[30:0];
            cur_y_q     <= s_axis_tdata_i[61:31];
            last_q      <= s_axis_tlast_i;
            first_q     <= !have_prev_q;
            have_prev_q <= !s_axis_tlast_i;
            if (!have_prev_q) begin
              hq_x_q <= s_axis_tdata_i[92:62];
              hq_y_q <= s_axis_tdata_i[123:93];
              best_q <= '1;
            end
            state_q <= S_PREP;
          end
        end
        S_PREP: begin
          px_q     <= px_d;
          py_q     <= py_d;
          dx_q     <= dx_d;
          dy_q     <= dy_d;
          rx_q     <= 34'(px_d);
          ry_q     <= 34'(py_d);
          prev_x_q <= cur_x_q;
          prev_y_q <= cur_y_q;
          if (first_q && !last_q) begin
            state_q <= S_IDLE;
          end else if (dx_d == '0 && dy_d == '0) begin
            state_q <= S_SQX;
          end else begin
            state_q <= S_NUM1;
          end
        end
        S_NUM1: state_q <= S_NUM2;
        S_NUM2: begin
          num_q   <= 66'(prod_q);
          state_q <= S_DEN1;
        end
        S_DEN1: begin
          num_q   <= num_q + 66'(prod_q);
          state_q <= S_DEN2;
        end
        S_DEN2: begin
          den_q   <= prod_q[63:0];
          state_q <= S_CLAMP;
        end
        S_CLAMP: begin
          den_q <= den_full;
          rem_q <= num_q[63:0];
          cnt_q <= '0;
          if (num_q <= 0) begin
            quo_q   <= '0;
            state_q <= S_OFFX;
          end else if (num_q[63:0] >= den_full) begin
            quo_q   <= {1'b1, 32'd0};
            state_q <= S_OFFX;
          end else begin
            quo_q   <= '0;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          rem_q <= div_ge ? 64'(rem_sh - {1'b0, den_q}) : rem_sh[63:0];
          quo_q <= {quo_q[31:0], div_ge};
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd31) begin
            state_q <= S_OFFX;
          end
        end
        S_OFFX: state_q <= S_OFFY;
        S_OFFY: begin
          rx_q    <= 34'(px_q) - prod_q[65:32];
          state_q <= S_RESY;
        end
        S_RESY: begin
          ry_q    <= 34'(py_q) - prod_q[65:32];
          state_q <= S_SQX;
        end
        S_SQX: state_q <= S_SQY;
        S_SQY: begin
          sq_q    <= prod_q[63:0];
          state_q <= S_SUM;
        end
        S_SUM: begin
          best_q <= best_new;
          rem_q  <= best_new;
          bit_q  <= 64'd1 << 62;
          res_q  <= '0;
          cnt_q  <= '0;
          state_q <= last_q ? S_SQRT : S_IDLE;
        end
        S_SQRT: begin
          if (sqrt_ge) begin
            rem_q <= rem_q - trial;
          end
          res_q <= res_next;
          bit_q <= bit_q >> 2;
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd31) begin
            dist_q  <= res_next[DIST_W-1:0];
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (m_axis_tready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // The block never takes a vertex while a result is on offer.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input ready while result valid");

  // An accepted vertex always starts work, so the input side closes.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("ready stayed high after accept");

  // Once a result transfer completes, the block is ready for a new polyline.
  a_out_then_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i) |=> (s_axis_tready_o && !have_prev_q))
    else $error("not idle after result transfer");
endmodule
